// ----- hdl/ialu_pkg.sv -----
`timescale 1ns / 1ps
package ialu_pkg;

   // Operation codes carried in the mode field.
   localparam logic [2:0] MODE_ADD  = 3'd0;
   localparam logic [2:0] MODE_SUB  = 3'd1;
   localparam logic [2:0] MODE_MUL  = 3'd2;
   localparam logic [2:0] MODE_DIV  = 3'd3;
   localparam logic [2:0] MODE_SQRT = 3'd4;

   // Error codes reported with each result.
   localparam logic [1:0] ERR_NONE     = 2'd0;
   localparam logic [1:0] ERR_DIV_ZERO = 2'd1;
   localparam logic [1:0] ERR_NEG_ROOT = 2'd2;

   // Width of the external operand and result fields.
   localparam int FIELD_WIDTH = 64;

   // Control information that travels with each transaction down the pipeline.
   typedef struct packed {
      logic       valid;
      logic [2:0] mode;
      logic [1:0] err;
      logic       a_neg;
      logic       b_neg;
   } ctrl_type;

endpackage

// ----- hdl/ialu_req_if.sv -----
`timescale 1ns / 1ps
interface ialu_req_if;
   import ialu_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [2:0]             mode;
   logic [FIELD_WIDTH-1:0] operand_a;
   logic [FIELD_WIDTH-1:0] operand_b;

   modport source (output valid, mode, operand_a, operand_b, input ready);
   modport sink   (input valid, mode, operand_a, operand_b, output ready);
endinterface

// ----- hdl/ialu_rsp_if.sv -----
`timescale 1ns / 1ps
interface ialu_rsp_if;
   import ialu_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [FIELD_WIDTH-1:0] result_value;
   logic [FIELD_WIDTH-1:0] remainder_value;
   logic [1:0]             error_code;

   modport source (output valid, result_value, remainder_value, error_code, input ready);
   modport sink   (input valid, result_value, remainder_value, error_code, output ready);
endinterface

// ----- hdl/ialu_stage.sv -----
`timescale 1ns / 1ps
module ialu_stage #(
   parameter int DATA_WIDTH = 64,
   parameter int STEP       = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  ialu_pkg::ctrl_type    ctrl_in,
   input  logic [DATA_WIDTH-1:0] x_in,
   input  logic [DATA_WIDTH-1:0] y_in,
   input  logic [DATA_WIDTH-1:0] acc_in,
   input  logic [DATA_WIDTH-1:0] r_in,
   input  logic [DATA_WIDTH-1:0] prod_in,
   output ialu_pkg::ctrl_type    ctrl_out,
   output logic [DATA_WIDTH-1:0] x_out,
   output logic [DATA_WIDTH-1:0] acc_out,
   output logic [DATA_WIDTH-1:0] r_out,
   output logic [DATA_WIDTH-1:0] y_out,
   output logic [DATA_WIDTH-1:0] prod_out
);
   import ialu_pkg::*;

   localparam int W       = DATA_WIDTH;
   localparam int SQ      = DATA_WIDTH / 2;
   localparam int SH      = (STEP < SQ) ? 2 * (SQ - 1 - STEP) : 0;
   localparam bit SQ_STEP = (STEP < SQ);

   ctrl_type       ctrl_ff;
   logic [W-1:0]   x_ff, x_in_nx;
   logic [W-1:0]   y_ff;
   logic [W-1:0]   acc_ff, acc_nx;
   logic [W-1:0]   r_ff, r_nx;
   logic [W-1:0]   prod_ff;
   logic [W:0]     shifted;
   logic [W-1:0]   root_bit;
   logic [W:0]     trial;

   // One restoring-division bit or one square-root digit per stage.
   always_comb begin
      shifted  = {r_in, x_in[W-1]};
      root_bit = W'(1) << SH;
      trial    = {1'b0, acc_in} + {1'b0, root_bit};
      x_in_nx  = x_in;
      acc_nx   = acc_in;
      r_nx     = r_in;
      if (ctrl_in.mode == MODE_DIV) begin
         x_in_nx = x_in << 1;
         if (shifted >= {1'b0, y_in}) begin
            r_nx   = W'(shifted - {1'b0, y_in});
            acc_nx = {acc_in[W-2:0], 1'b1};
         end else begin
            r_nx   = shifted[W-1:0];
            acc_nx = {acc_in[W-2:0], 1'b0};
         end
      end else if (ctrl_in.mode == MODE_SQRT && SQ_STEP) begin
         if ({1'b0, x_in} >= trial) begin
            x_in_nx = x_in - trial[W-1:0];
            acc_nx  = (acc_in >> 1) + root_bit;
         end else begin
            acc_nx  = acc_in >> 1;
         end
      end
   end

   // Only the valid bit resets; the other control fields and the payload only follow the pipeline enable.
   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff.valid <= 1'b0;
      end else if (advance) begin
         ctrl_ff.valid <= ctrl_in.valid;
      end
      if (advance) begin
         ctrl_ff.mode  <= ctrl_in.mode;
         ctrl_ff.err   <= ctrl_in.err;
         ctrl_ff.a_neg <= ctrl_in.a_neg;
         ctrl_ff.b_neg <= ctrl_in.b_neg;
         x_ff          <= x_in_nx;
         y_ff          <= y_in;
         acc_ff        <= acc_nx;
         r_ff          <= r_nx;
         prod_ff       <= prod_in;
      end
   end

   assign ctrl_out = ctrl_ff;
   assign x_out    = x_ff;
   assign y_out    = y_ff;
   assign acc_out  = acc_ff;
   assign r_out    = r_ff;
   assign prod_out = prod_ff;
endmodule

// ----- hdl/integer_alu_div_sqrt.sv -----
`timescale 1ns / 1ps
// Throughput: one transaction per cycle while the pipeline advances; each of the
// DATA_WIDTH iteration stages resolves one quotient bit, and the first DATA_WIDTH/2
// also one root digit. The whole pipeline holds while a finished response waits and
// rsp_ch is not ready. Reset is synchronous and active high; it clears the valid
// bits of all stages.
module integer_alu_div_sqrt #(
   parameter int DATA_WIDTH = 64
) (
   input  logic              clock,
   input  logic              reset,
   ialu_req_if.sink          req_ch,
   ialu_rsp_if.source        rsp_ch
);
   import ialu_pkg::*;

   localparam int W  = DATA_WIDTH;
   localparam int LO = (DATA_WIDTH + 1) / 2;
   localparam int HI = DATA_WIDTH - LO;

   logic advance;

   // Entry stage signals.
   logic [W-1:0] a_w, b_w, ua, ub, x_in, addsub_in;
   logic [1:0]   err_in;
   logic [2*LO-1:0] pp0_w;
   logic [W-1:0] pp1_w, pp2_w;
   ctrl_type     ent_ff;
   logic [W-1:0] ent_x_ff, ent_y_ff, addsub_ff;
   logic [W-1:0] pp0_ff, pp1_ff, pp2_ff;

   // Product summing stage.
   ctrl_type     sum_ff;
   logic [W-1:0] sum_x_ff, sum_y_ff, prod_ff, prod_in;

   // Iteration chain.
   ctrl_type     c_s   [0:W];
   logic [W-1:0] x_s   [0:W];
   logic [W-1:0] y_s   [0:W];
   logic [W-1:0] acc_s [0:W];
   logic [W-1:0] r_s   [0:W];
   logic [W-1:0] p_s   [0:W];

   // Output register.
   logic                   out_valid_ff;
   logic [FIELD_WIDTH-1:0] res_ff, rem_ff, res_in, rem_in;
   logic [1:0]             err_ff;
   logic [W-1:0]           res_w, rem_w;
   ctrl_type               last;

   // The whole pipeline moves unless a response is held back.
   assign advance      = !out_valid_ff || rsp_ch.ready;
   assign req_ch.ready = advance;

   // Operand decode, magnitudes, add and subtract, partial products.
   always_comb begin
      a_w       = req_ch.operand_a[W-1:0];
      b_w       = req_ch.operand_b[W-1:0];
      ua        = a_w[W-1] ? W'(-a_w) : a_w;
      ub        = b_w[W-1] ? W'(-b_w) : b_w;
      addsub_in = (req_ch.mode == MODE_SUB) ? W'(a_w - b_w) : W'(a_w + b_w);
      pp0_w     = {{LO{1'b0}}, a_w[LO-1:0]} * {{LO{1'b0}}, b_w[LO-1:0]};
      pp1_w     = {{HI{1'b0}}, a_w[LO-1:0]} * {{LO{1'b0}}, b_w[W-1:LO]};
      pp2_w     = {{LO{1'b0}}, a_w[W-1:LO]} * {{HI{1'b0}}, b_w[LO-1:0]};
      err_in    = ERR_NONE;
      x_in      = a_w;
      if (req_ch.mode == MODE_DIV) begin
         x_in = ua;
         if (b_w == '0) begin
            err_in = ERR_DIV_ZERO;
         end
      end else if (req_ch.mode == MODE_SQRT && a_w[W-1]) begin
         err_in = ERR_NEG_ROOT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ent_ff.valid <= 1'b0;
      end else if (advance) begin
         ent_ff.valid <= req_ch.valid;
      end
      if (advance) begin
         ent_ff.mode  <= req_ch.mode;
         ent_ff.err   <= err_in;
         ent_ff.a_neg <= a_w[W-1];
         ent_ff.b_neg <= b_w[W-1];
         ent_x_ff     <= x_in;
         ent_y_ff     <= ub;
         addsub_ff    <= addsub_in;
         pp0_ff       <= W'(pp0_w);
         pp1_ff       <= pp1_w;
         pp2_ff       <= pp2_w;
      end
   end

   // Product modulo 2^W from three partial products, else the add or subtract result.
   always_comb begin
      if (ent_ff.mode == MODE_MUL) begin
         prod_in = pp0_ff + W'((pp1_ff + pp2_ff) << LO);
      end else begin
         prod_in = addsub_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff.valid <= 1'b0;
      end else if (advance) begin
         sum_ff.valid <= ent_ff.valid;
      end
      if (advance) begin
         sum_ff.mode  <= ent_ff.mode;
         sum_ff.err   <= ent_ff.err;
         sum_ff.a_neg <= ent_ff.a_neg;
         sum_ff.b_neg <= ent_ff.b_neg;
         sum_x_ff     <= ent_x_ff;
         sum_y_ff     <= ent_y_ff;
         prod_ff      <= prod_in;
      end
   end

   assign c_s[0]   = sum_ff;
   assign x_s[0]   = sum_x_ff;
   assign y_s[0]   = sum_y_ff;
   assign acc_s[0] = '0;
   assign r_s[0]   = '0;
   assign p_s[0]   = prod_ff;

   // Division and root iteration stages.
   for (genvar k = 0; k < W; k++) begin : g_stage
      ialu_stage #(
         .DATA_WIDTH (W),
         .STEP       (k)
      ) u_stage (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .ctrl_in  (c_s[k]),
         .x_in     (x_s[k]),
         .y_in     (y_s[k]),
         .acc_in   (acc_s[k]),
         .r_in     (r_s[k]),
         .prod_in  (p_s[k]),
         .ctrl_out (c_s[k+1]),
         .x_out    (x_s[k+1]),
         .acc_out  (acc_s[k+1]),
         .r_out    (r_s[k+1]),
         .y_out    (y_s[k+1]),
         .prod_out (p_s[k+1])
      );
   end

   // Sign fix-up and result selection.
   always_comb begin
      last  = c_s[W];
      res_w = '0;
      rem_w = '0;
      if (last.err == ERR_NONE) begin
         case (last.mode)
            MODE_ADD, MODE_SUB, MODE_MUL: begin
               res_w = p_s[W];
            end
            MODE_DIV: begin
               res_w = (last.a_neg != last.b_neg) ? W'(-acc_s[W]) : acc_s[W];
               rem_w = last.a_neg ? W'(-r_s[W]) : r_s[W];
            end
            MODE_SQRT: begin
               res_w = acc_s[W];
            end
            default: begin
               res_w = '0;
            end
         endcase
      end
      res_in = FIELD_WIDTH'(signed'(res_w));
      rem_in = FIELD_WIDTH'(signed'(rem_w));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= last.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         res_ff <= res_in;
         rem_ff <= rem_in;
         err_ff <= last.err;
      end
   end

   assign rsp_ch.valid           = out_valid_ff;
   assign rsp_ch.result_value    = res_ff;
   assign rsp_ch.remainder_value = rem_ff;
   assign rsp_ch.error_code      = err_ff;
endmodule

// ----- verif/tb_integer_alu_div_sqrt.sv -----
`timescale 1ns / 1ps
module tb_integer_alu_div_sqrt;
   import ialu_pkg::*;

   localparam int DW = 64;
   localparam int LATENCY = DW + 3;
   localparam longint CYCLE_LIMIT = 400000;

   typedef logic [63:0] word_type;

   typedef struct packed {
      word_type   quot;
      word_type   rem;
      logic [1:0] err;
   } answer_type;

   typedef struct {
      logic [2:0] mode;
      word_type   a;
      word_type   b;
      logic       known;
      answer_type ans;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ialu_req_if req_ch ();
   ialu_rsp_if rsp_ch ();

   integer_alu_div_sqrt #(.DATA_WIDTH(DW)) u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   always #6 clock = ~clock;

   answer_type answers_due[$];
   int      fail_count = 0;
   int      ops_sent = 0;
   int      answers_seen = 0;
   longint  cycle_count = 0;
   int      send_idle_pct = 0;
   int      recv_stall_pct = 0;

   // Integer root by the digit-by-digit method.
   function automatic word_type isqrt(word_type n);
      word_type bitv, acc;
      bitv = 64'd1 << 62;
      acc = 0;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (n >= acc + bitv) begin
            n = n - (acc + bitv);
            acc = (acc >> 1) + bitv;
         end else begin
            acc = acc >> 1;
         end
         bitv = bitv >> 2;
      end
      return acc;
   endfunction

   // Computes the expected answer of one operation.
   function automatic answer_type alu_answer(logic [2:0] mode, word_type a, word_type b);
      answer_type r;
      word_type ua, ub, q, m;
      r.quot = 0;
      r.rem = 0;
      r.err = ERR_NONE;
      case (mode)
         MODE_ADD: r.quot = a + b;
         MODE_SUB: r.quot = a - b;
         MODE_MUL: r.quot = a * b;
         MODE_DIV: begin
            if (b == 0) begin
               r.err = ERR_DIV_ZERO;
            end else begin
               ua = a[63] ? -a : a;
               ub = b[63] ? -b : b;
               q = ua / ub;
               m = ua % ub;
               r.quot = (a[63] != b[63]) ? -q : q;
               r.rem = a[63] ? -m : m;
            end
         end
         MODE_SQRT: begin
            if (a[63]) r.err = ERR_NEG_ROOT;
            else r.quot = isqrt(a);
         end
         default: ;
      endcase
      return r;
   endfunction

   // Response checker and receiver stall.
   always @(posedge clock) begin
      answer_type exp_ans;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         answers_seen <= answers_seen + 1;
         if (answers_due.size() == 0) begin
            $display("%0t: unexpected response %h %h %0d", $time, rsp_ch.result_value,
                     rsp_ch.remainder_value, rsp_ch.error_code);
            fail_count++;
         end else begin
            exp_ans = answers_due.pop_front();
            if (rsp_ch.result_value !== exp_ans.quot ||
                rsp_ch.remainder_value !== exp_ans.rem ||
                rsp_ch.error_code !== exp_ans.err) begin
               $display("%0t: mismatch expected %h %h %0d actual %h %h %0d", $time,
                        exp_ans.quot, exp_ans.rem, exp_ans.err, rsp_ch.result_value,
                        rsp_ch.remainder_value, rsp_ch.error_code);
               fail_count++;
            end
         end
      end
   end

   always @(negedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Sends one transaction; the predictor runs at acceptance.
   task automatic send_op(logic [2:0] mode, word_type a, word_type b);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.mode <= mode;
      req_ch.operand_a <= a;
      req_ch.operand_b <= b;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      answers_due.push_back(alu_answer(mode, a, b));
      ops_sent++;
   endtask

   task automatic drain();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (answers_due.size() != 0) @(posedge clock);
   endtask

   function automatic word_type rand_word();
      word_type w;
      w = {$urandom, $urandom};
      case ($urandom_range(5))
         0: w = w >> $urandom_range(63);
         1: w = -(w >> $urandom_range(63));
         2: w = 64'($urandom_range(20)) - 64'd10;
         default: ;
      endcase
      return w;
   endfunction

   localparam word_type MAXP = 64'h7fff_ffff_ffff_ffff;
   localparam word_type MINN = 64'h8000_0000_0000_0000;
   localparam word_type ALL1 = 64'hffff_ffff_ffff_ffff;

   stim_row_type directed[] = '{
      '{MODE_ADD, MAXP, 64'd1, 1'b1, '{MINN, 64'd0, ERR_NONE}},
      '{MODE_ADD, ALL1, ALL1, 1'b0, '{0, 0, 0}},
      '{MODE_SUB, MINN, 64'd1, 1'b1, '{MAXP, 64'd0, ERR_NONE}},
      '{MODE_SUB, 64'd0, MINN, 1'b0, '{0, 0, 0}},
      '{MODE_MUL, MAXP, MAXP, 1'b0, '{0, 0, 0}},
      '{MODE_MUL, MINN, ALL1, 1'b1, '{MINN, 64'd0, ERR_NONE}},
      '{MODE_DIV, 64'd7, 64'd0, 1'b1, '{64'd0, 64'd0, ERR_DIV_ZERO}},
      '{MODE_DIV, MINN, ALL1, 1'b1, '{MINN, 64'd0, ERR_NONE}},
      '{MODE_DIV, -64'd7, 64'd2, 1'b0, '{0, 0, 0}},
      '{MODE_DIV, 64'd7, -64'd2, 1'b0, '{0, 0, 0}},
      '{MODE_DIV, MAXP, MINN, 1'b0, '{0, 0, 0}},
      '{MODE_DIV, MINN, 64'd3, 1'b0, '{0, 0, 0}},
      '{MODE_SQRT, 64'd0, ALL1, 1'b1, '{64'd0, 64'd0, ERR_NONE}},
      '{MODE_SQRT, MINN, 64'd0, 1'b1, '{64'd0, 64'd0, ERR_NEG_ROOT}},
      '{MODE_SQRT, ALL1, 64'd0, 1'b1, '{64'd0, 64'd0, ERR_NEG_ROOT}},
      '{MODE_SQRT, MAXP, 64'd0, 1'b0, '{0, 0, 0}},
      '{MODE_SQRT, 64'd1 << 30, 64'd0, 1'b1, '{64'd1 << 15, 64'd0, ERR_NONE}},
      '{MODE_SQRT, 64'd99, 64'd0, 1'b1, '{64'd9, 64'd0, ERR_NONE}},
      '{3'd5, MAXP, MAXP, 1'b1, '{64'd0, 64'd0, ERR_NONE}},
      '{3'd6, MINN, ALL1, 1'b1, '{64'd0, 64'd0, ERR_NONE}},
      '{3'd7, ALL1, ALL1, 1'b1, '{64'd0, 64'd0, ERR_NONE}}
   };

   initial begin
      answer_type typed_in;
      int      phase;
      logic [2:0] mode;
      req_ch.valid = 1'b0;
      req_ch.mode = MODE_ADD;
      req_ch.operand_a = '0;
      req_ch.operand_b = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed table; typed-in answers of the known rows are cross-checked against the predictor.
      foreach (directed[i]) begin
         if (directed[i].known) begin
            typed_in = alu_answer(directed[i].mode, directed[i].a, directed[i].b);
            if (typed_in != directed[i].ans) begin
               $display("%0t: row %0d expected %h %h %0d actual %h %h %0d", $time, i,
                        directed[i].ans.quot, directed[i].ans.rem, directed[i].ans.err,
                        typed_in.quot, typed_in.rem, typed_in.err);
               fail_count++;
            end
         end
         send_op(directed[i].mode, directed[i].a, directed[i].b);
      end
      drain();

      // Random operations in four phases: no idling, sender idling, receiver stalling, and both.
      for (phase = 0; phase < 4; phase++) begin
         send_idle_pct = (phase == 1 || phase == 3) ? ((phase == 1) ? 49 : 13) : 0;
         recv_stall_pct = (phase == 2 || phase == 3) ? ((phase == 2) ? 49 : 13) : 0;
         repeat (200) begin
            mode = ($urandom_range(15) == 0) ? 3'($urandom_range(7, 5))
                                              : 3'($urandom_range(4));
            send_op(mode, rand_word(), ($urandom_range(20) == 0) ? 64'd0 : rand_word());
         end
         drain();
      end

      repeat (2 * LATENCY) @(posedge clock);
      $display("Covered %0d transactions, %0d responses: all modes, unused codes,",
               ops_sent, answers_seen);
      $display("errors and operand extremes under sender and receiver idling.");
      if (fail_count == 0 && answers_due.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
